// ===== hdl/fpgt_pkg.sv =====
// Shared types, constants and tables for the fuzzy PID gain tuner.
// Holds item structs, membership breakpoints, rule tables and defuzzifier constants.
// No dependencies.
package fpgt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int GRADE_SHIFT = 16;
  localparam int GRADE_W     = 17;
  localparam int DIV_STEPS   = 17;

  localparam logic [GRADE_W-1:0] GRADE_ONE = 17'h10000;

  localparam logic [1:0] SET_D1  = 2'd0;
  localparam logic [1:0] SET_D10 = 2'd1;
  localparam logic [1:0] SET_D50 = 2'd2;

  localparam logic [2:0] LAB_NB = 3'd0;
  localparam logic [2:0] LAB_PB = 3'd6;

  localparam logic [1:0] K_KP = 2'd0;
  localparam logic [1:0] K_KI = 2'd1;
  localparam logic [1:0] K_KD = 2'd2;

  localparam logic [1:0] REG_KP = 2'd0;
  localparam logic [1:0] REG_KI = 2'd1;
  localparam logic [1:0] REG_KD = 2'd2;

  typedef logic signed [19:0] bp_t;

  typedef struct packed {
    logic               cmd;
    logic signed [19:0] error_value;
    logic signed [19:0] error_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] kp_gain_out;
    logic signed [31:0] ki_gain_out;
    logic signed [31:0] kd_gain_out;
    logic [2:0]         rule_row;
    logic [2:0]         rule_col;
    logic [16:0]        rule_strength;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic               fixed;
    logic [GRADE_W-1:0] fixed_val;
    logic [17:0]        num;
    logic [17:0]        den;
  } fz_t;

  typedef struct packed {
    logic signed [40:0] base;
    logic signed [20:0] coef;
    logic               sh17;
  } dz_t;

  localparam logic signed [2:0] SHAPE [0:6][0:2] = '{
    '{-3'sd3, -3'sd1,  3'sd0},
    '{-3'sd3, -3'sd2,  3'sd0},
    '{-3'sd3, -3'sd1,  3'sd1},
    '{-3'sd2,  3'sd0,  3'sd2},
    '{-3'sd1,  3'sd1,  3'sd3},
    '{ 3'sd0,  3'sd2,  3'sd3},
    '{ 3'sd1,  3'sd3,  3'sd0}
  };

  localparam logic [2:0] KP_RULES [0:6][0:6] = '{
    '{3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3},
    '{3'd6, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd3},
    '{3'd5, 3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd2},
    '{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1},
    '{3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1},
    '{3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0},
    '{3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0}
  };

  localparam logic [2:0] KD_RULES [0:6][0:6] = '{
    '{3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd1, 3'd4},
    '{3'd4, 3'd2, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3},
    '{3'd3, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3},
    '{3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3},
    '{3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3},
    '{3'd6, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6},
    '{3'd6, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd6}
  };

  localparam logic [2:0] KI_RULES [0:6][0:6] = '{
    '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3},
    '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3},
    '{3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4},
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5},
    '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6},
    '{3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6},
    '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6}
  };

  // breakpoint k/den rounded to nearest, negatives by symmetry
  function automatic bp_t bp(input logic signed [2:0] k, input logic [1:0] set);
    logic [1:0]  mag;
    logic [19:0] val;
    mag = k[2] ? 2'(-k) : 2'(k);
    val = '0;
    unique case (set)
      SET_D1: begin
        val = 20'(mag) << FRAC_BITS;
      end
      SET_D10: begin
        unique case (mag)
          2'd1:    val = 20'd6554;
          2'd2:    val = 20'd13107;
          2'd3:    val = 20'd19661;
          default: val = 20'd0;
        endcase
      end
      SET_D50: begin
        unique case (mag)
          2'd1:    val = 20'd1311;
          2'd2:    val = 20'd2621;
          2'd3:    val = 20'd3932;
          default: val = 20'd0;
        endcase
      end
      default: val = 20'd0;
    endcase
    return k[2] ? -$signed(val) : $signed(val);
  endfunction

  function automatic dz_t dz_const(input logic [2:0] lab, input logic [1:0] set);
    dz_t d;
    logic signed [40:0] a;
    logic signed [40:0] b;
    logic signed [40:0] c;
    a = 41'(bp(SHAPE[lab][0], set));
    b = 41'(bp(SHAPE[lab][1], set));
    c = 41'(bp(SHAPE[lab][2], set));
    if (lab == LAB_NB) begin
      d.base = b <<< GRADE_SHIFT;
      d.coef = 21'(a - b);
      d.sh17 = 1'b0;
    end else if (lab == LAB_PB) begin
      d.base = a <<< GRADE_SHIFT;
      d.coef = 21'(b - a);
      d.sh17 = 1'b0;
    end else begin
      d.base = (a + c) <<< GRADE_SHIFT;
      d.coef = 21'((b - a) - (c - b));
      d.sh17 = 1'b1;
    end
    return d;
  endfunction

endpackage

// ===== hdl/fpgt_div.sv =====
// Shared restoring divider: one quotient bit per cycle, quotient below 2^17.
// Divides num * 2^16 by den to form a Q1.16 membership grade.
// Depends on fpgt_pkg.
module fpgt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [17:0]                   num,
  input  logic [17:0]                   den,
  output logic                          done,
  output logic [fpgt_pkg::GRADE_W-1:0]  quot
);

  logic                          busy_r;
  logic                          done_r;
  logic [4:0]                    cnt_r;
  logic [33:0]                   rem_r;
  logic [33:0]                   dsh_r;
  logic [fpgt_pkg::GRADE_W-1:0]  quot_r;
  logic                          ge;

  assign ge   = rem_r >= dsh_r;
  assign done = done_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(fpgt_pkg::DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {num, 16'd0};
      dsh_r  <= {den, 16'd0};
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r  <= dsh_r >> 1;
      quot_r <= {quot_r[fpgt_pkg::GRADE_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/fpgt_fuzz.sv =====
// Membership front end: picks the segment of one label for one input value.
// Gives a fixed grade or the numerator and denominator for the divider.
// Depends on fpgt_pkg.
module fpgt_fuzz (
  input  logic signed [19:0] x,
  input  logic [2:0]         lab,
  input  logic               rate_sel,
  output fpgt_pkg::fz_t      fz
);

  logic [1:0]         set;
  logic signed [20:0] a;
  logic signed [20:0] b;
  logic signed [20:0] c;
  logic signed [20:0] xe;

  assign set = rate_sel ? fpgt_pkg::SET_D10 : fpgt_pkg::SET_D1;
  assign a   = 21'(fpgt_pkg::bp(fpgt_pkg::SHAPE[lab][0], set));
  assign b   = 21'(fpgt_pkg::bp(fpgt_pkg::SHAPE[lab][1], set));
  assign c   = 21'(fpgt_pkg::bp(fpgt_pkg::SHAPE[lab][2], set));
  assign xe  = 21'(x);

  always_comb begin
    fz = '0;
    if (lab == fpgt_pkg::LAB_NB) begin
      if (xe <= a) begin
        fz.fixed     = 1'b1;
        fz.fixed_val = fpgt_pkg::GRADE_ONE;
      end else if (xe <= b) begin
        fz.num = 18'(b - xe);
        fz.den = 18'(b - a);
      end else begin
        fz.fixed = 1'b1;
      end
    end else if (lab == fpgt_pkg::LAB_PB) begin
      if (xe <= a) begin
        fz.fixed = 1'b1;
      end else if (xe < b) begin
        fz.num = 18'(xe - a);
        fz.den = 18'(b - a);
      end else begin
        fz.fixed     = 1'b1;
        fz.fixed_val = fpgt_pkg::GRADE_ONE;
      end
    end else begin
      if (xe <= a) begin
        fz.fixed = 1'b1;
      end else if (xe <= b) begin
        fz.num = 18'(xe - a);
        fz.den = 18'(b - a);
      end else if (xe <= c) begin
        fz.num = 18'(c - xe);
        fz.den = 18'(c - b);
      end else begin
        fz.fixed = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/fuzzy_pid_gain_tuner.sv =====
// Fuzzy self-tuning PID gains, 7x7 rule base, one shared bit-serial divider.
// Tune item: 14 grades (7 labels each for error and rate), each direct or via the divider,
// then a search of all 49 rules for the strongest, a defuzzify of Kp, Ki and Kd, and result.
// Reload item: result is valid in the cycle after acceptance. One item at a time.
// Synchronous active-low reset clears the initial-gain registers and the gains.
module fuzzy_pid_gain_tuner (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fpgt_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fpgt_pkg::out_item_t   out_item,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GRADE = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_SAT   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [2:0] LAST_IDX = 3'd6;

  localparam logic signed [33:0] GMAX = 34'sd2147483647;
  localparam logic signed [33:0] GMIN = -34'sd2147483648;

  logic [2:0] state_r, state_nxt;
  logic [2:0] lab_r, lab_nxt;
  logic       set_r, set_nxt;
  logic [2:0] i_r, i_nxt;
  logic [2:0] j_r, j_nxt;
  logic [1:0] k_r, k_nxt;

  logic signed [31:0] kpi_r, kii_r, kdi_r;
  logic signed [31:0] gain_r [0:2];

  logic signed [19:0]            e_r, ec_r;
  logic [fpgt_pkg::GRADE_W-1:0]  eg_r [0:6];
  logic [fpgt_pkg::GRADE_W-1:0]  rg_r [0:6];
  logic [fpgt_pkg::GRADE_W-1:0]  best_r;
  logic [2:0]                    row_r, col_r;
  logic signed [38:0]            prod_r;
  logic signed [23:0]            delta_r;
  logic                          sat_r;

  fpgt_pkg::fz_t                 fz;
  logic                          div_start;
  logic                          div_done;
  logic [fpgt_pkg::GRADE_W-1:0]  div_quot;
  logic                          grade_we;
  logic [fpgt_pkg::GRADE_W-1:0]  grade_val;
  logic                          accept;

  logic [fpgt_pkg::GRADE_W-1:0]  w;
  logic [2:0]                    dz_lab;
  logic [1:0]                    dz_set;
  fpgt_pkg::dz_t                 dz;
  logic signed [38:0]            prod;
  logic signed [40:0]            v;
  logic [40:0]                   vmag;
  logic [40:0]                   rsum;
  logic [40:0]                   rsh;
  logic signed [23:0]            delta;
  logic signed [33:0]            gsum;
  logic signed [31:0]            gnew;
  logic                          govf;

  assign accept    = (state_r == S_IDLE) && in_valid;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  assign out_item.kp_gain_out   = gain_r[0];
  assign out_item.ki_gain_out   = gain_r[1];
  assign out_item.kd_gain_out   = gain_r[2];
  assign out_item.rule_row      = row_r;
  assign out_item.rule_col      = col_r;
  assign out_item.rule_strength = best_r;
  assign out_item.saturated     = sat_r;

  fpgt_fuzz u_fuzz (
    .x        (set_r ? ec_r : e_r),
    .lab      (lab_r),
    .rate_sel (set_r),
    .fz       (fz)
  );

  fpgt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (fz.num),
    .den   (fz.den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign w = (eg_r[i_r] < rg_r[j_r]) ? eg_r[i_r] : rg_r[j_r];

  always_comb begin
    unique case (k_r)
      fpgt_pkg::K_KP: begin
        dz_lab = fpgt_pkg::KP_RULES[row_r][col_r];
        dz_set = fpgt_pkg::SET_D10;
      end
      fpgt_pkg::K_KI: begin
        dz_lab = fpgt_pkg::KI_RULES[row_r][col_r];
        dz_set = fpgt_pkg::SET_D50;
      end
      default: begin
        dz_lab = fpgt_pkg::KD_RULES[row_r][col_r];
        dz_set = fpgt_pkg::SET_D1;
      end
    endcase
  end

  assign dz   = fpgt_pkg::dz_const(dz_lab, dz_set);
  assign prod = 39'(dz.coef * $signed({1'b0, best_r}));

  // round to nearest, halves away from zero
  assign v     = dz.base + 41'(prod_r);
  assign vmag  = v[40] ? 41'(-v) : 41'(v);
  assign rsum  = dz.sh17 ? vmag + (41'd1 << fpgt_pkg::GRADE_SHIFT)
                         : vmag + (41'd1 << (fpgt_pkg::GRADE_SHIFT - 1));
  assign rsh   = dz.sh17 ? rsum >> (fpgt_pkg::GRADE_SHIFT + 1)
                         : rsum >> fpgt_pkg::GRADE_SHIFT;
  assign delta = v[40] ? -$signed(24'(rsh)) : $signed(24'(rsh));

  assign gsum = 34'(gain_r[k_r]) + 34'(delta_r);
  always_comb begin
    govf = 1'b0;
    gnew = 32'(gsum);
    if (gsum > GMAX) begin
      govf = 1'b1;
      gnew = 32'(GMAX);
    end else if (gsum < GMIN) begin
      govf = 1'b1;
      gnew = 32'(GMIN);
    end
  end

  always_comb begin
    state_nxt = state_r;
    lab_nxt   = lab_r;
    set_nxt   = set_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    div_start = 1'b0;
    grade_we  = 1'b0;
    grade_val = fz.fixed_val;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_item.cmd ? S_OUT : S_GRADE;
          lab_nxt   = fpgt_pkg::LAB_NB;
          set_nxt   = 1'b0;
        end
      end
      S_GRADE, S_DIV: begin
        if (state_r == S_GRADE && !fz.fixed) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (state_r == S_GRADE || div_done) begin
          grade_we  = 1'b1;
          grade_val = (state_r == S_DIV) ? div_quot : fz.fixed_val;
          if (lab_r == fpgt_pkg::LAB_PB) begin
            if (!set_r) begin
              set_nxt   = 1'b1;
              lab_nxt   = fpgt_pkg::LAB_NB;
              state_nxt = S_GRADE;
            end else begin
              i_nxt     = '0;
              j_nxt     = '0;
              state_nxt = S_SRCH;
            end
          end else begin
            lab_nxt   = lab_r + 3'd1;
            state_nxt = S_GRADE;
          end
        end
      end
      S_SRCH: begin
        if (j_r == LAST_IDX) begin
          j_nxt = '0;
          if (i_r == LAST_IDX) begin
            k_nxt     = fpgt_pkg::K_KP;
            state_nxt = S_MUL;
          end else begin
            i_nxt = i_r + 3'd1;
          end
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: state_nxt = S_SAT;
      S_SAT: begin
        if (k_r == fpgt_pkg::K_KD) begin
          state_nxt = S_OUT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lab_r     <= '0;
      set_r     <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      kpi_r     <= '0;
      kii_r     <= '0;
      kdi_r     <= '0;
      gain_r[0] <= '0;
      gain_r[1] <= '0;
      gain_r[2] <= '0;
    end else begin
      state_r <= state_nxt;
      lab_r   <= lab_nxt;
      set_r   <= set_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          fpgt_pkg::REG_KP: kpi_r <= cfg_data;
          fpgt_pkg::REG_KI: kii_r <= cfg_data;
          fpgt_pkg::REG_KD: kdi_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept && in_item.cmd) begin
        gain_r[0] <= kpi_r;
        gain_r[1] <= kii_r;
        gain_r[2] <= kdi_r;
      end else if (state_r == S_SAT) begin
        gain_r[k_r] <= gnew;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_r    <= in_item.error_value;
      ec_r   <= in_item.error_rate;
      sat_r  <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
      best_r <= '0;
    end
    if (grade_we) begin
      if (set_r) begin
        rg_r[lab_r] <= grade_val;
      end else begin
        eg_r[lab_r] <= grade_val;
      end
    end
    if (state_r == S_SRCH) begin
      if (((i_r == '0) && (j_r == '0)) || (w > best_r)) begin
        best_r <= w;
        row_r  <= i_r;
        col_r  <= j_r;
      end
    end
    if (state_r == S_MUL) begin
      prod_r <= prod;
    end
    if (state_r == S_ADD) begin
      delta_r <= delta;
    end
    if (state_r == S_SAT) begin
      sat_r <= sat_r | govf;
    end
  end

endmodule

// ===== bench/fuzzy_pid_gain_tuner_chk.sv =====
// Checker for the fuzzy PID gain tuner: watches both channels and the config port,
// predicts every result item and compares the whole item, showing each field on a mismatch. Depends on fpgt_pkg.
`timescale 1ns / 1ps
module fuzzy_pid_gain_tuner_chk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  fpgt_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  fpgt_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);

  localparam longint ONE = 65536;
  localparam int SH [0:6][0:2] = '{'{-3,-1,0}, '{-3,-2,0}, '{-3,-1,1}, '{-2,0,2},
                                   '{-1,1,3}, '{0,2,3}, '{1,3,0}};
  localparam int KP_T [0:6][0:6] = '{'{6,6,5,5,4,3,3}, '{6,6,5,4,4,3,3},
    '{5,5,5,4,3,2,2}, '{5,5,4,3,2,1,1}, '{4,4,3,2,2,1,1}, '{4,3,2,1,1,1,0},
    '{3,3,1,1,1,0,0}};
  localparam int KD_T [0:6][0:6] = '{'{4,2,0,0,0,1,4}, '{4,2,0,1,1,2,3},
    '{3,2,1,1,2,2,3}, '{3,2,2,2,2,2,3}, '{3,3,3,3,3,3,3}, '{6,2,4,4,4,4,6},
    '{6,5,5,5,4,4,6}};
  localparam int KI_T [0:6][0:6] = '{'{0,0,1,1,2,3,3}, '{0,0,1,2,2,3,3},
    '{0,1,2,2,3,4,4}, '{1,1,2,3,4,5,5}, '{1,2,3,4,4,5,6}, '{3,3,4,4,5,6,6},
    '{3,3,4,5,5,6,6}};

  logic signed [31:0] init_gain [0:2];
  logic signed [31:0] kp_q, ki_q, kd_q;
  fpgt_pkg::out_item_t gains_due [$];

  function automatic longint brk(int k, longint den);
    longint m;
    m = k < 0 ? -k : k;
    m = ((m << 17) + den) / (2 * den);
    return k < 0 ? -m : m;
  endfunction

  function automatic longint memb(longint x, int lab, longint den);
    longint a, b, c;
    a = brk(SH[lab][0], den);
    b = brk(SH[lab][1], den);
    c = brk(SH[lab][2], den);
    if (lab == 0) begin
      if (x <= a) return ONE;
      if (x <= b) return ((b - x) * ONE) / (b - a);
      return 0;
    end
    if (lab == 6) begin
      if (x <= a) return 0;
      if (x < b) return ((x - a) * ONE) / (b - a);
      return ONE;
    end
    if (x <= a) return 0;
    if (x <= b) return ((x - a) * ONE) / (b - a);
    if (x <= c) return ((c - x) * ONE) / (c - b);
    return 0;
  endfunction

  function automatic longint rnd_shift(longint v, int sh);
    longint half;
    half = 64'sd1 << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint delta(longint s, int lab, longint den);
    longint a, b, c;
    a = brk(SH[lab][0], den);
    b = brk(SH[lab][1], den);
    c = brk(SH[lab][2], den);
    if (lab == 0) return rnd_shift(b * ONE - (b - a) * s, 16);
    if (lab == 6) return rnd_shift(a * ONE + (b - a) * s, 16);
    return rnd_shift((a + c) * ONE + ((b - a) - (c - b)) * s, 17);
  endfunction

  function automatic logic signed [31:0] clamp_add(logic signed [31:0] g, longint d,
                                                   inout logic sat);
    longint v;
    v = longint'(g) + d;
    if (v > 64'sd2147483647) begin sat = 1'b1; return 32'sh7fffffff; end
    if (v < -64'sd2147483648) begin sat = 1'b1; return 32'sh80000000; end
    return v[31:0];
  endfunction

  task automatic tune_gains(fpgt_pkg::in_item_t it);
    fpgt_pkg::out_item_t r;
    longint eg [0:6];
    longint rg [0:6];
    longint best, w;
    int row, col;
    logic sat;
    row = 0; col = 0; sat = 1'b0; best = 0;
    if (it.cmd) begin
      kp_q = init_gain[0]; ki_q = init_gain[1]; kd_q = init_gain[2];
    end else begin
      for (int i = 0; i < 7; i++) begin
        eg[i] = memb(longint'(it.error_value), i, 1);
        rg[i] = memb(longint'(it.error_rate), i, 10);
      end
      best = eg[0] < rg[0] ? eg[0] : rg[0];
      for (int i = 0; i < 7; i++)
        for (int j = 0; j < 7; j++) begin
          w = eg[i] < rg[j] ? eg[i] : rg[j];
          if (w > best) begin best = w; row = i; col = j; end
        end
      kp_q = clamp_add(kp_q, delta(best, KP_T[row][col], 10), sat);
      ki_q = clamp_add(ki_q, delta(best, KI_T[row][col], 50), sat);
      kd_q = clamp_add(kd_q, delta(best, KD_T[row][col], 1), sat);
    end
    r.kp_gain_out = kp_q;
    r.ki_gain_out = ki_q;
    r.kd_gain_out = kd_q;
    r.rule_row = 3'(row);
    r.rule_col = 3'(col);
    r.rule_strength = 17'(best);
    r.saturated = sat;
    gains_due.push_back(r);
  endtask

  assign pending = gains_due.size();

  always @(posedge clk) begin
    fpgt_pkg::out_item_t e;
    if (!rst_n) begin
      init_gain[0] <= '0; init_gain[1] <= '0; init_gain[2] <= '0;
      kp_q <= '0; ki_q <= '0; kd_q <= '0;
      fail_count <= 0;
      gains_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (gains_due.size() == 0) begin
          $display("%0t unexpected item %h", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          e = gains_due.pop_front();
          if (e !== out_item) begin
            $display("%0t mismatch exp kp %h ki %h kd %h r %0d c %0d s %h sat %b", $time,
                     e.kp_gain_out, e.ki_gain_out, e.kd_gain_out, e.rule_row, e.rule_col,
                     e.rule_strength, e.saturated);
            $display("%0t          got kp %h ki %h kd %h r %0d c %0d s %h sat %b", $time,
                     out_item.kp_gain_out, out_item.ki_gain_out, out_item.kd_gain_out,
                     out_item.rule_row, out_item.rule_col, out_item.rule_strength,
                     out_item.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) tune_gains(in_item);
      if (cfg_we && cfg_index < 2'd3) init_gain[cfg_index] <= cfg_data;
    end
  end
endmodule

// ===== bench/fuzzy_pid_gain_tuner_tb.sv =====
// Top of the fuzzy PID gain tuner bench: clock, reset, stimulus and verdict.
// Depends on fpgt_pkg, fuzzy_pid_gain_tuner and fuzzy_pid_gain_tuner_chk.
`timescale 1ns / 1ps
module fuzzy_pid_gain_tuner_tb;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  fpgt_pkg::in_item_t in_item;
  fpgt_pkg::out_item_t out_item;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending;
  bit hold_off;

  fuzzy_pid_gain_tuner u_dut (.*);
  fuzzy_pid_gain_tuner_chk u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  task automatic send_item(logic cmd, logic [19:0] ev, logic [19:0] er);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.cmd <= cmd;
    in_item.error_value <= ev;
    in_item.error_rate <= er;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(negedge clk);
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  function automatic logic [19:0] pick_value(int scale);
    case ($urandom_range(0, 5))
      0: return 20'($urandom);
      1: return $urandom_range(0, 1) ? 20'h7ffff : 20'h80000;
      2: return 20'(int'($urandom_range(0, 2 * scale)) - scale);
      3: return 20'((int'($urandom_range(0, 6)) - 3) * scale / 3);
      default: return 20'(int'($urandom_range(0, 8 * scale)) - 4 * scale);
    endcase
  endfunction

  task automatic set_initials(int mode);
    for (int r = 0; r < 3; r++)
      case (mode)
        0: write_reg(2'(r), 32'h7fffff00);
        1: write_reg(2'(r), 32'h80000100);
        2: write_reg(2'(r), 32'h0);
        default: write_reg(2'(r), $urandom);
      endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap != 0 || hold_off) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        while (hold_off) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int ev_edges [0:8];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_off = 1'b0;
    ev_edges = '{-524288, -196608, -131072, -65536, 0, 65536, 131072, 196608, 524287};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < 9; i++) send_item(1'b0, 20'(ev_edges[i]), 20'(ev_edges[8 - i]));
    send_item(1'b0, 20'h7ffff, 20'h7ffff);
    send_item(1'b0, 20'h80000, 20'h80000);
    send_item(1'b0, 20'd19661, -20'sd6554);
    send_item(1'b0, 20'd32768, 20'd3277);
    send_item(1'b1, 20'h7ffff, 20'h80000);
    settle();
    set_initials(0);
    send_item(1'b1, 20'h0, 20'h0);
    for (int i = 0; i < 6; i++) send_item(1'b0, 20'h80000, 20'h80000);
    settle();
    set_initials(1);
    send_item(1'b1, 20'hfffff, 20'hfffff);
    for (int i = 0; i < 6; i++) send_item(1'b0, 20'h7ffff, 20'h7ffff);

    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_item(1'b0, pick_value(65536), pick_value(6554));
    join

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      set_initials(ph == 4 ? 2 : 3);
      for (int i = 0; i < 330; i++)
        send_item($urandom_range(0, 15) == 0, pick_value(65536 * 3), pick_value(6554 * 3));
    end

    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
